@@ design/gbns_pkg.sv @@
// Shared types, codes and constants for the go-back-N sender window block.
package gbns_pkg;

    // Fixed field widths
    localparam int MSG_W     = 16;
    localparam int SEQ_OUT_W = 16;
    localparam int PAY_W     = 8;
    localparam int DIV_CNT_W = $clog2(MSG_W + 1);
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;

    // Defaults handed to the top level parameters
    localparam int WINDOW_DEF      = 8;
    localparam int SEQ_BITS_DEF    = 16;
    localparam int QUEUE_LIMIT_DEF = 1024;
    localparam logic [PAY_W-1:0] PAYLOAD_RST = 8'd124;

    // Event kinds on the input side
    typedef enum logic [1:0] {
        CMD_MSG = 2'd0,
        CMD_PKT = 2'd1,
        CMD_TMR = 2'd2,
        CMD_RSV = 2'd3
    } t_cmd_code;

    // Result kinds on the output side
    typedef enum logic [1:0] {
        KIND_SEND    = 2'd0,
        KIND_RESEND  = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_REFUSE  = 2'd3
    } t_kind;

    // Which result the datapath is to build this cycle
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_SEND,
        EMIT_RESEND,
        EMIT_RESTART,
        EMIT_REFUSE
    } t_emit;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_ADMIT,
        ST_REFUSE,
        ST_FILL,
        ST_RESEND
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic  load;
        logic  div_start;
        logic  div_step;
        logic  admit;
        logic  slide;
        logic  resend_start;
        logic  timer_off;
        t_emit emit;
        logic  last;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_cmd_code cmd;
        logic      ack_ok;
        logic      outs_zero;
        logic      ack_match;
        logic      div_done;
        logic      refused;
        logic      can_send;
        logic      send_last;
        logic      resend_last;
        logic      restart_pend;
        logic      out_free;
    } t_dp_status;

endpackage

@@ design/gbns_dp.sv @@
// Datapath: sequence state, ceiling divider, admission, result register.
module gbns_dp #(
    parameter int WINDOW      = gbns_pkg::WINDOW_DEF,
    parameter int SEQ_BITS    = gbns_pkg::SEQ_BITS_DEF,
    parameter int QUEUE_LIMIT = gbns_pkg::QUEUE_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gbns_pkg::t_dp_cmd                 i_cmd,
    output gbns_pkg::t_dp_status              o_status,
    input  logic                              i_cfg_wr_en,
    input  logic [gbns_pkg::PAY_W-1:0]        i_cfg_wr_data,
    input  logic [gbns_pkg::IN_DATA_W-1:0]    i_in_tdata,
    input  logic [gbns_pkg::IN_USER_W-1:0]    i_in_tuser,
    input  logic                              i_out_tready,
    output logic                              o_out_tvalid,
    output logic [gbns_pkg::OUT_DATA_W-1:0]   o_out_tdata,
    output logic [gbns_pkg::OUT_USER_W-1:0]   o_out_tuser,
    output logic                              o_out_tlast
);

    localparam int IdxW = (WINDOW > 1) ? $clog2(WINDOW + 1) : 1;
    localparam int CmpW = (SEQ_BITS > 17) ? SEQ_BITS : 17;
    localparam longint unsigned SeqSpace = 64'd1 << SEQ_BITS;
    localparam longint unsigned SeqRoom  = SeqSpace - 64'(WINDOW) - 64'd1;
    localparam longint unsigned CapL     =
        (SeqRoom < 64'(QUEUE_LIMIT)) ? SeqRoom : 64'(QUEUE_LIMIT);
    localparam logic [SEQ_BITS-1:0] CapV = SEQ_BITS'(CapL);
    localparam logic [SEQ_BITS-1:0] WinV = SEQ_BITS'(WINDOW);
    localparam logic [SEQ_BITS-1:0] One  = SEQ_BITS'(1);

    // Registers
    logic [gbns_pkg::PAY_W-1:0]     r_payload;
    logic [SEQ_BITS-1:0]            r_base, n_base;
    logic [SEQ_BITS-1:0]            r_nts, n_nts;
    logic [SEQ_BITS-1:0]            r_nta, n_nta;
    logic                           r_armed, n_armed;
    logic                           r_restart, n_restart;
    logic                           r_refused;
    logic [IdxW-1:0]                r_idx, n_idx;
    gbns_pkg::t_cmd_code            r_cmd;
    logic                           r_ack_ok;
    logic [gbns_pkg::MSG_W-1:0]     r_msg;
    logic [gbns_pkg::SEQ_OUT_W-1:0] r_ack_seq;
    logic [gbns_pkg::PAY_W-1:0]     r_div_rem;
    logic [gbns_pkg::MSG_W-1:0]     r_div_quo;
    logic [gbns_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic                           r_out_valid;
    gbns_pkg::t_kind                r_out_kind;
    logic [gbns_pkg::SEQ_OUT_W-1:0] r_out_seq;
    logic                           r_out_tr;
    logic                           r_out_last;

    // Combinational values
    logic [SEQ_BITS-1:0]            w_outs;
    logic [SEQ_BITS-1:0]            w_queued;
    logic [SEQ_BITS-1:0]            w_room;
    logic [gbns_pkg::PAY_W-1:0]     w_divisor;
    logic [gbns_pkg::PAY_W:0]       w_trial;
    logic                           w_trial_ge;
    logic [16:0]                    w_segs;
    logic                           w_refuse;
    logic [CmpW-1:0]                w_admit;
    logic                           w_can_send;
    logic                           w_out_free;
    logic [SEQ_BITS-1:0]            w_rs_seq;
    gbns_pkg::t_kind                n_out_kind;
    logic [gbns_pkg::SEQ_OUT_W-1:0] n_out_seq;
    logic                           n_out_tr;

    assign w_outs     = r_nts - r_base;
    assign w_queued   = r_nta - r_nts;
    assign w_can_send = (w_outs < WinV) && (w_queued != '0);
    assign w_out_free = !r_out_valid || i_out_tready;
    assign w_rs_seq   = r_base + SEQ_BITS'(r_idx);

    // One restoring divide step per cycle; payload zero counts as one
    assign w_divisor  = (r_payload == '0) ? gbns_pkg::PAY_W'(1) : r_payload;
    assign w_trial    = {r_div_rem, r_div_quo[gbns_pkg::MSG_W-1]};
    assign w_trial_ge = w_trial >= {1'b0, w_divisor};

    // Round the quotient up and clip it to the free queue room
    assign w_segs   = {1'b0, r_div_quo} + 17'(r_div_rem != '0);
    assign w_room   = (w_queued < CapV) ? (CapV - w_queued) : '0;
    assign w_refuse = CmpW'(w_segs) > CmpW'(w_room);
    assign w_admit  = w_refuse ? CmpW'(w_room) : CmpW'(w_segs);

    // Status toward the controller
    always_comb begin
        o_status.cmd          = r_cmd;
        o_status.ack_ok       = r_ack_ok;
        o_status.outs_zero    = (w_outs == '0);
        o_status.ack_match    = (gbns_pkg::SEQ_OUT_W'(r_base) == r_ack_seq);
        o_status.div_done     = (r_div_cnt == gbns_pkg::DIV_CNT_W'(gbns_pkg::MSG_W));
        o_status.refused      = r_refused;
        o_status.can_send     = w_can_send;
        o_status.send_last    = ((w_outs + One) == WinV) || (w_queued == One);
        o_status.resend_last  = ((SEQ_BITS'(r_idx) + One) == w_outs);
        o_status.restart_pend = r_restart;
        o_status.out_free     = w_out_free;
    end

    // Next sequence state
    always_comb begin
        n_base    = r_base;
        n_nts     = r_nts;
        n_nta     = r_nta;
        n_armed   = r_armed;
        n_restart = r_restart;
        n_idx     = r_idx;
        if (i_cmd.admit) begin
            n_nta = r_nta + SEQ_BITS'(w_admit);
        end
        if (i_cmd.slide) begin
            n_base    = r_base + One;
            n_armed   = 1'b1;
            n_restart = 1'b1;
        end
        if (i_cmd.resend_start) begin
            n_idx   = '0;
            n_armed = 1'b1;
        end
        if (i_cmd.timer_off) begin
            n_armed = 1'b0;
        end
        case (i_cmd.emit)
            gbns_pkg::EMIT_SEND: begin
                n_nts     = r_nts + One;
                n_armed   = 1'b1;
                n_restart = 1'b0;
            end
            gbns_pkg::EMIT_RESTART: n_restart = 1'b0;
            gbns_pkg::EMIT_RESEND:  n_idx = r_idx + IdxW'(1);
            default: ;
        endcase
    end

    // Build the result for this emit
    always_comb begin
        n_out_kind = gbns_pkg::KIND_REFUSE;
        n_out_seq  = '0;
        n_out_tr   = 1'b0;
        case (i_cmd.emit)
            gbns_pkg::EMIT_SEND: begin
                n_out_kind = gbns_pkg::KIND_SEND;
                n_out_seq  = gbns_pkg::SEQ_OUT_W'(r_nts);
                n_out_tr   = r_restart || !r_armed;
            end
            gbns_pkg::EMIT_RESEND: begin
                n_out_kind = gbns_pkg::KIND_RESEND;
                n_out_seq  = gbns_pkg::SEQ_OUT_W'(w_rs_seq);
                n_out_tr   = (r_idx == '0);
            end
            gbns_pkg::EMIT_RESTART: begin
                n_out_kind = gbns_pkg::KIND_RESTART;
                n_out_tr   = 1'b1;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload   <= gbns_pkg::PAYLOAD_RST;
            r_base      <= '0;
            r_nts       <= '0;
            r_nta       <= '0;
            r_armed     <= 1'b0;
            r_restart   <= 1'b0;
            r_refused   <= 1'b0;
            r_idx       <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_payload <= i_cfg_wr_data;
            end
            r_base    <= n_base;
            r_nts     <= n_nts;
            r_nta     <= n_nta;
            r_armed   <= n_armed;
            r_restart <= n_restart;
            r_idx     <= n_idx;
            if (i_cmd.admit) begin
                r_refused <= w_refuse;
            end
            if (i_cmd.div_start) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + gbns_pkg::DIV_CNT_W'(1);
            end
            if (i_cmd.emit != gbns_pkg::EMIT_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: request latch, divider, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd     <= gbns_pkg::t_cmd_code'(i_in_tuser[1:0]);
            r_ack_ok  <= i_in_tuser[2];
            r_msg     <= i_in_tdata[15:0];
            r_ack_seq <= i_in_tdata[31:16];
        end
        if (i_cmd.div_start) begin
            r_div_rem <= '0;
            r_div_quo <= r_msg;
        end else if (i_cmd.div_step) begin
            r_div_rem <= w_trial_ge ? gbns_pkg::PAY_W'(w_trial - {1'b0, w_divisor})
                                    : gbns_pkg::PAY_W'(w_trial);
            r_div_quo <= {r_div_quo[gbns_pkg::MSG_W-2:0], w_trial_ge};
        end
        if (i_cmd.emit != gbns_pkg::EMIT_NONE) begin
            r_out_kind <= n_out_kind;
            r_out_seq  <= n_out_seq;
            r_out_tr   <= n_out_tr;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_tvalid = r_out_valid;
    assign o_out_tdata  = {7'd0, r_out_tr, r_out_seq};
    assign o_out_tuser  = r_out_kind;
    assign o_out_tlast  = r_out_last;

`ifndef ASSERT_OFF
    // Outstanding count never exceeds the window
    a_outs_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_outs <= WinV)
        else $error("outstanding count above window");

    // Queue never grows past its capacity
    a_queue_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_queued <= CapV)
        else $error("queued count above capacity");

    // A result held under back-pressure is not overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_tready) |-> (i_cmd.emit == gbns_pkg::EMIT_NONE))
        else $error("result register overwritten while stalled");
`endif

endmodule

@@ design/gbns_ctrl.sv @@
// Controller: sequences decode, division, admission, window fill and resend.
module gbns_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_tvalid,
    output logic                 o_in_tready,
    input  gbns_pkg::t_dp_status i_status,
    output gbns_pkg::t_dp_cmd    o_cmd
);

    gbns_pkg::t_state r_state, n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbns_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbns_pkg::ST_IDLE: begin
                if (i_in_tvalid) n_state = gbns_pkg::ST_DECODE;
            end
            gbns_pkg::ST_DECODE: begin
                unique case (i_status.cmd)
                    gbns_pkg::CMD_MSG: n_state = gbns_pkg::ST_DIV;
                    gbns_pkg::CMD_PKT: begin
                        if (!i_status.ack_ok || i_status.outs_zero) begin
                            n_state = gbns_pkg::ST_IDLE;
                        end else if (i_status.ack_match) begin
                            n_state = gbns_pkg::ST_FILL;
                        end else begin
                            n_state = gbns_pkg::ST_RESEND;
                        end
                    end
                    gbns_pkg::CMD_TMR: begin
                        n_state = i_status.outs_zero ? gbns_pkg::ST_IDLE
                                                     : gbns_pkg::ST_RESEND;
                    end
                    gbns_pkg::CMD_RSV: n_state = gbns_pkg::ST_IDLE;
                endcase
            end
            gbns_pkg::ST_DIV: begin
                if (i_status.div_done) n_state = gbns_pkg::ST_ADMIT;
            end
            gbns_pkg::ST_ADMIT: n_state = gbns_pkg::ST_REFUSE;
            gbns_pkg::ST_REFUSE: begin
                // A refusal with nothing to send ends the request
                if (i_status.refused && i_status.out_free && !i_status.can_send) begin
                    n_state = gbns_pkg::ST_IDLE;
                end else if (!i_status.refused || i_status.out_free) begin
                    n_state = gbns_pkg::ST_FILL;
                end
            end
            gbns_pkg::ST_FILL: begin
                if (i_status.out_free && i_status.can_send && i_status.send_last) begin
                    n_state = gbns_pkg::ST_IDLE;
                end else if (!i_status.can_send
                             && (!i_status.restart_pend || i_status.out_free)) begin
                    n_state = gbns_pkg::ST_IDLE;
                end
            end
            gbns_pkg::ST_RESEND: begin
                if (i_status.out_free && i_status.resend_last) n_state = gbns_pkg::ST_IDLE;
            end
            default: n_state = gbns_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_in_tready        = 1'b0;
        o_cmd.load         = 1'b0;
        o_cmd.div_start    = 1'b0;
        o_cmd.div_step     = 1'b0;
        o_cmd.admit        = 1'b0;
        o_cmd.slide        = 1'b0;
        o_cmd.resend_start = 1'b0;
        o_cmd.timer_off    = 1'b0;
        o_cmd.emit         = gbns_pkg::EMIT_NONE;
        o_cmd.last         = 1'b0;
        unique case (r_state)
            gbns_pkg::ST_IDLE: begin
                o_in_tready = 1'b1;
                o_cmd.load  = i_in_tvalid;
            end
            gbns_pkg::ST_DECODE: begin
                unique case (i_status.cmd)
                    gbns_pkg::CMD_MSG: o_cmd.div_start = 1'b1;
                    gbns_pkg::CMD_PKT: begin
                        if (i_status.ack_ok && !i_status.outs_zero) begin
                            o_cmd.slide        = i_status.ack_match;
                            o_cmd.resend_start = !i_status.ack_match;
                        end
                    end
                    gbns_pkg::CMD_TMR: begin
                        o_cmd.timer_off    = i_status.outs_zero;
                        o_cmd.resend_start = !i_status.outs_zero;
                    end
                    gbns_pkg::CMD_RSV: ;
                endcase
            end
            gbns_pkg::ST_DIV: o_cmd.div_step = !i_status.div_done;
            gbns_pkg::ST_ADMIT: o_cmd.admit = 1'b1;
            gbns_pkg::ST_REFUSE: begin
                if (i_status.refused && i_status.out_free) begin
                    o_cmd.emit = gbns_pkg::EMIT_REFUSE;
                    o_cmd.last = !i_status.can_send;
                end
            end
            gbns_pkg::ST_FILL: begin
                if (i_status.out_free) begin
                    if (i_status.can_send) begin
                        o_cmd.emit = gbns_pkg::EMIT_SEND;
                        o_cmd.last = i_status.send_last;
                    end else if (i_status.restart_pend) begin
                        o_cmd.emit = gbns_pkg::EMIT_RESTART;
                        o_cmd.last = 1'b1;
                    end
                end
            end
            gbns_pkg::ST_RESEND: begin
                if (i_status.out_free) begin
                    o_cmd.emit = gbns_pkg::EMIT_RESEND;
                    o_cmd.last = i_status.resend_last;
                end
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    // A new send is only issued while the window has room and the queue is not empty
    a_send_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit == gbns_pkg::EMIT_SEND) |-> i_status.can_send)
        else $error("send issued without window room");

    // The last result of a request returns the controller to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit != gbns_pkg::EMIT_NONE && o_cmd.last) |=> (r_state == gbns_pkg::ST_IDLE))
        else $error("last result issued but request still running");
`endif

endmodule

@@ design/go_back_n_sender_window_top.sv @@
// Top level of the go-back-N sender window block.
// Go-back-N sender control kept on sequence numbers only. One request is taken at a time:
// the block accepts a request in idle, decodes it, and then issues results at up to one
// per cycle while the receiver takes them, through a registered output, which may still
// hold the final result while the next request is taken. A message request runs a
// ceiling division of its size by the payload size one quotient bit per cycle (16 steps),
// then admits the segments and then checks for a refusal, before its sends. An ack
// request gives one result per segment sent or resent (at most the window), or one
// timer-restart result; a timer request resends each outstanding segment; an ignored
// request gives no result. Back-pressure on the output stalls the results. The payload
// size register may be written only while no request is in progress.
module go_back_n_sender_window_top #(
    parameter int WINDOW      = gbns_pkg::WINDOW_DEF,
    parameter int SEQ_BITS    = gbns_pkg::SEQ_BITS_DEF,
    parameter int QUEUE_LIMIT = gbns_pkg::QUEUE_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [gbns_pkg::PAY_W-1:0]      i_cfg_wr_data,    // payload_bytes
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [gbns_pkg::IN_DATA_W-1:0]  s_axis_tdata,     // msg_size, ack_seq
    input  logic [gbns_pkg::IN_USER_W-1:0]  s_axis_tuser,     // cmd, ack_ok
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [gbns_pkg::OUT_DATA_W-1:0] m_axis_tdata,     // sent_seq, timer_restart, zeros
    output logic [gbns_pkg::OUT_USER_W-1:0] m_axis_tuser,     // kind
    output logic                            m_axis_tlast      // last
);

    gbns_pkg::t_dp_cmd    w_cmd;
    gbns_pkg::t_dp_status w_status;

    // Sequence each request
    gbns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (s_axis_tvalid),
        .o_in_tready (s_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Hold window state and build results
    gbns_dp #(
        .WINDOW      (WINDOW),
        .SEQ_BITS    (SEQ_BITS),
        .QUEUE_LIMIT (QUEUE_LIMIT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_tdata    (s_axis_tdata),
        .i_in_tuser    (s_axis_tuser),
        .i_out_tready  (m_axis_tready),
        .o_out_tvalid  (m_axis_tvalid),
        .o_out_tdata   (m_axis_tdata),
        .o_out_tuser   (m_axis_tuser),
        .o_out_tlast   (m_axis_tlast)
    );

endmodule

@@ tb/go_back_n_sender_window_top_tb.sv @@
// Testbench for the go-back-N sender window: directed and random events checked against a predictor.
module go_back_n_sender_window_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_CAP =
        (gbns_pkg::QUEUE_LIMIT_DEF <
         (1 << gbns_pkg::SEQ_BITS_DEF) - gbns_pkg::WINDOW_DEF - 1) ?
        gbns_pkg::QUEUE_LIMIT_DEF :
        (1 << gbns_pkg::SEQ_BITS_DEF) - gbns_pkg::WINDOW_DEF - 1;
    // Cycles to let a request without results finish before a register write
    localparam int SETTLE_CYCLES = 40;
    // Long receiver hold-off that backs the block up into its input
    localparam int HOLD_CYCLES   = 300;
    // Cycles without any handshake on either side before the run is stopped
    localparam int QUIET_LIMIT   = 2000;
    // Room for expected results not yet seen on the output
    localparam int NOTE_DEPTH    = 64;

    // One expected result
    typedef struct packed {
        gbns_pkg::t_kind kind;
        logic [15:0]     seq;
        logic            restart;
        logic            last;
    } t_tx_note;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_wr_en = 1'b0;
    logic [gbns_pkg::PAY_W-1:0]        i_cfg_wr_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [gbns_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;   // msg_size, ack_seq
    logic [gbns_pkg::IN_USER_W-1:0]    s_axis_tuser = '0;   // cmd, ack_ok
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [gbns_pkg::OUT_DATA_W-1:0]   m_axis_tdata;        // sent_seq, timer_restart, zeros
    logic [gbns_pkg::OUT_USER_W-1:0]   m_axis_tuser;        // kind
    logic                              m_axis_tlast;        // last

    // Predicted sender state
    logic [15:0]  win_base = '0;
    logic [15:0]  send_ptr = '0;
    logic [15:0]  assign_ptr = '0;
    logic         timer_on = 1'b0;
    logic [7:0]   seg_bytes = gbns_pkg::PAYLOAD_RST;

    // Expected results, oldest at note_rd
    t_tx_note     note_mem [NOTE_DEPTH];
    int unsigned  note_wr = 0;
    int unsigned  note_rd = 0;
    int unsigned  note_pending = 0;
    t_tx_note     held_note;
    int unsigned  note_cnt;

    int unsigned  send_idle_pct = 0;
    int unsigned  stall_pct = 0;
    bit           hold_req = 1'b0;
    int unsigned  hold_left = 0;
    int unsigned  quiet_cycles = 0;
    int unsigned  fault_cnt = 0;

    go_back_n_sender_window_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [15:0] in_flight();
        in_flight = send_ptr - win_base;
    endfunction

    function automatic logic [15:0] queued_cnt();
        queued_cnt = assign_ptr - send_ptr;
    endfunction

    function automatic int unsigned eff_payload();
        eff_payload = (seg_bytes == 8'd0) ? 1 : seg_bytes;
    endfunction

    // Append one expected result behind the others
    function automatic void stash_note(t_tx_note nt);
        if (note_pending >= NOTE_DEPTH) begin
            $error("expected results overflow their store");
            fault_cnt++;
        end else begin
            note_mem[note_wr] = nt;
            note_wr = (note_wr + 1) % NOTE_DEPTH;
            note_pending++;
        end
    endfunction

    // Hold back the newest result so the final one of a request can be marked last
    function automatic void note(gbns_pkg::t_kind k, logic [15:0] s, logic r);
        if (note_cnt != 0) stash_note(held_note);
        held_note = '{kind: k, seq: s, restart: r, last: 1'b0};
        note_cnt++;
    endfunction

    // Send queued segments until the window is full or the queue is empty; note a pending restart if none went
    function automatic void refill_window(input logic restart_in);
        logic pend;
        pend = restart_in;
        while (in_flight() < gbns_pkg::WINDOW_DEF && queued_cnt() != 0) begin
            note(gbns_pkg::KIND_SEND, send_ptr, pend | ~timer_on);
            timer_on = 1'b1;
            pend = 1'b0;
            send_ptr = send_ptr + 16'd1;
        end
        if (pend) note(gbns_pkg::KIND_RESTART, 16'd0, 1'b1);
    endfunction

    // Go back: resend every outstanding segment
    function automatic void resend_window();
        logic [15:0] cnt;
        cnt = in_flight();
        timer_on = 1'b1;
        for (int unsigned i = 0; i < cnt; i++)
            note(gbns_pkg::KIND_RESEND, win_base + 16'(i), i == 0);
    endfunction

    // Advance the predicted state by one accepted request and queue its results
    function automatic void gbn_window_step(gbns_pkg::t_cmd_code cmd, logic [15:0] size,
                                            logic ok, logic [15:0] ack);
        int unsigned p, segs, backlog, room;
        note_cnt = 0;
        case (cmd)
            gbns_pkg::CMD_MSG: begin
                p = eff_payload();
                segs = (int'(size) + p - 1) / p;
                backlog = queued_cnt();
                room = (backlog < QUEUE_CAP) ? QUEUE_CAP - backlog : 0;
                if (segs > room) begin
                    segs = room;
                    note(gbns_pkg::KIND_REFUSE, 16'd0, 1'b0);
                end
                assign_ptr = assign_ptr + 16'(segs);
                refill_window(1'b0);
            end
            gbns_pkg::CMD_PKT: begin
                if (ok && in_flight() != 0) begin
                    if (ack == win_base) begin
                        win_base = win_base + 16'd1;
                        timer_on = 1'b1;
                        refill_window(1'b1);
                    end else begin
                        resend_window();
                    end
                end
            end
            gbns_pkg::CMD_TMR: begin
                timer_on = 1'b0;
                if (in_flight() != 0) resend_window();
            end
            default: ;
        endcase
        if (note_cnt != 0) begin
            held_note.last = 1'b1;
            stash_note(held_note);
        end
    endfunction

    // Offer one request, wait for the handshake, then predict its results
    task automatic send_event(gbns_pkg::t_cmd_code cmd, logic [15:0] size, logic ok,
                              logic [15:0] ack);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ack, size};
        s_axis_tuser  <= {ok, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        gbn_window_step(cmd, size, ok, ack);
    endtask

    // Drop valid, let every result drain and the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (note_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_payload(logic [7:0] val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        seg_bytes = val;
    endtask

    // Split messages at the reset payload size and fill the window
    task automatic test_message_split();
        send_event(gbns_pkg::CMD_MSG, 16'd0, 1'b0, 16'd0);
        send_event(gbns_pkg::CMD_MSG, 16'd1, 1'b1, 16'hFFFF);
        send_event(gbns_pkg::CMD_MSG, 16'd372, 1'b0, 16'd0);
        send_event(gbns_pkg::CMD_MSG, 16'd744, 1'b0, 16'd0);
    endtask

    // Invalid packet, wrong ack, matching ack
    task automatic test_ack_handling();
        send_event(gbns_pkg::CMD_PKT, 16'hFFFF, 1'b0, win_base);
        send_event(gbns_pkg::CMD_PKT, 16'd0, 1'b1, 16'hFFFF);
        send_event(gbns_pkg::CMD_PKT, 16'd0, 1'b1, win_base);
    endtask

    // Timer expiry with a full window, and the unknown command
    task automatic test_timer_expiry();
        send_event(gbns_pkg::CMD_TMR, 16'd0, 1'b0, 16'd0);
        send_event(gbns_pkg::CMD_RSV, 16'hFFFF, 1'b1, 16'hFFFF);
    endtask

    // Ack everything out, then ack and expire on an empty window
    task automatic test_window_drain();
        while (in_flight() != 0)
            send_event(gbns_pkg::CMD_PKT, 16'($urandom_range(0, 65535)), 1'b1, win_base);
        send_event(gbns_pkg::CMD_PKT, 16'd0, 1'b1, win_base);
        send_event(gbns_pkg::CMD_TMR, 16'd0, 1'b0, 16'd0);
    endtask

    // Payload size zero counts as one byte
    task automatic test_zero_payload();
        set_payload(8'd0);
        send_event(gbns_pkg::CMD_MSG, 16'd3, 1'b0, 16'd0);
        send_event(gbns_pkg::CMD_MSG, 16'd0, 1'b0, 16'd0);
    endtask

    // Hold the receiver off for a long stretch while requests keep coming
    task automatic test_output_hold();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) begin
            if (i % 3 == 0)
                send_event(gbns_pkg::CMD_MSG, 16'(eff_payload() * 4), 1'b0, 16'd0);
            else
                send_event(gbns_pkg::CMD_PKT, 16'd0, 1'b1, win_base);
        end
    endtask

    // Random mix of messages, acks and timer events
    task automatic run_traffic(int unsigned count, int unsigned idle_pct,
                               int unsigned stall_in, logic [7:0] pay);
        int unsigned pick, sub, msg_pct, p;
        logic [15:0] rnd_a, rnd_b;
        set_payload(pay);
        send_idle_pct = idle_pct;
        stall_pct = stall_in;
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            sub = $urandom_range(0, 99);
            rnd_a = 16'($urandom_range(0, 65535));
            rnd_b = 16'($urandom_range(0, 65535));
            p = eff_payload();
            // Throttle messages while the backlog is deep so acks can drain it
            msg_pct = (int'(in_flight()) + int'(queued_cnt()) < 24) ? 35 : 8;
            if (pick < msg_pct) begin
                if (sub < 90)
                    send_event(gbns_pkg::CMD_MSG, 16'($urandom_range(0, 2 * p)),
                               rnd_a[0], rnd_b);
                else
                    send_event(gbns_pkg::CMD_MSG, 16'($urandom_range(0, 8 * p)),
                               rnd_a[0], rnd_b);
            end else if (pick < 88) begin
                if (sub < 80)
                    send_event(gbns_pkg::CMD_PKT, rnd_a, 1'b1, win_base);
                else if (sub < 90)
                    send_event(gbns_pkg::CMD_PKT, rnd_a, 1'b1, rnd_b);
                else
                    send_event(gbns_pkg::CMD_PKT, rnd_a, 1'b0, rnd_b);
            end else if (pick < 97) begin
                send_event(gbns_pkg::CMD_TMR, rnd_a, sub[0], rnd_b);
            end else begin
                send_event(gbns_pkg::CMD_RSV, rnd_a, sub[0], rnd_b);
            end
        end
    endtask

    // Overfill the segment queue at both payload extremes
    task automatic test_queue_full();
        send_idle_pct = 0;
        stall_pct = 0;
        set_payload(8'd1);
        send_event(gbns_pkg::CMD_MSG, 16'hFFFF, 1'b0, 16'd0);
        send_event(gbns_pkg::CMD_MSG, 16'd7, 1'b0, 16'd0);
        send_event(gbns_pkg::CMD_TMR, 16'd0, 1'b0, 16'd0);
        send_event(gbns_pkg::CMD_PKT, 16'd0, 1'b1, win_base);
        set_payload(8'd255);
        send_event(gbns_pkg::CMD_MSG, 16'hFFFF, 1'b0, 16'd0);
    endtask

    // Drive the receiver ready, with random stalls and the long hold-off
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_tx_note want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (note_pending == 0) begin
                $error("result with none expected: kind %0d seq %0d",
                       m_axis_tuser, m_axis_tdata[15:0]);
                fault_cnt++;
            end else begin
                want = note_mem[note_rd];
                note_rd = (note_rd + 1) % NOTE_DEPTH;
                note_pending--;
                if (m_axis_tuser != want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    fault_cnt++;
                end
                if (m_axis_tdata[15:0] != want.seq) begin
                    $error("sent_seq: expected %0d, got %0d", want.seq, m_axis_tdata[15:0]);
                    fault_cnt++;
                end
                if (m_axis_tdata[16] != want.restart) begin
                    $error("timer_restart: expected %0d, got %0d", want.restart,
                           m_axis_tdata[16]);
                    fault_cnt++;
                end
                if (m_axis_tdata[gbns_pkg::OUT_DATA_W-1:17] != '0) begin
                    $error("tdata pad: expected 0, got %0h",
                           m_axis_tdata[gbns_pkg::OUT_DATA_W-1:17]);
                    fault_cnt++;
                end
                if (m_axis_tlast != want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    fault_cnt++;
                end
            end
        end
    end

    // Stop the run when nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_message_split();
        test_ack_handling();
        test_timer_expiry();
        test_window_drain();
        test_zero_payload();
        test_output_hold();
        run_traffic(96, 0, 0, 8'($urandom_range(2, 254)));
        run_traffic(96, 76, 0, 8'd1);
        run_traffic(96, 0, 76, 8'd255);
        run_traffic(96, 9, 9, 8'($urandom_range(1, 255)));
        test_queue_full();

        wait_idle();
        if (fault_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
